>>> hw/rtl/pcicfg_pkg.sv
package pcicfg_pkg;

  localparam int SPACE_BYTES = 256;
  localparam int ADDR_W      = $clog2(SPACE_BYTES);

  typedef enum logic [0:0] {
    CMD_READ  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_t;

  // Write behavior of a writable byte
  typedef enum logic [1:0] {
    WK_MASKED,   // byte <= data & mask
    WK_CLEAR,    // byte <= byte & data & mask (write-zero-to-clear status)
    WK_ONCE,     // byte <= data while byte is zero
    WK_SMRAM     // byte <= data while lock bit is clear
  } wr_kind_t;

  localparam int NUM_WR        = 43;
  localparam int SUBSYS_IDX    = 4;    // first write-once subsystem byte, 0x2c
  localparam int SMRAM_IDX     = 21;
  localparam int SMRAM_LOCK_BIT = 1;

  localparam logic [7:0] ABSENT_FN_DATA = 8'hff;

  localparam logic [ADDR_W-1:0] WR_ADDR [NUM_WR] = '{
    8'h04, 8'h06, 8'h07, 8'h13, 8'h2c, 8'h2d, 8'h2e, 8'h2f,
    8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h56, 8'h59,
    8'h5a, 8'h5b, 8'h5c, 8'h5d, 8'h5e, 8'h5f,
    8'h70, 8'h72, 8'h73, 8'h92, 8'h93, 8'h94,
    8'h98, 8'h99, 8'h9a, 8'h9b, 8'h9d, 8'ha8, 8'ha9, 8'hb0, 8'hb4,
    8'hb9, 8'hba, 8'hbb, 8'hbc, 8'hbd, 8'hbe, 8'hcb
  };

  localparam logic [7:0] WR_MASK [NUM_WR] = '{
    8'hff, 8'h90, 8'hff, 8'hfe, 8'hff, 8'hff, 8'hff, 8'hff,
    8'hdc, 8'h07, 8'hff, 8'hf7, 8'hff, 8'h80, 8'h30,
    8'h33, 8'h33, 8'h33, 8'h33, 8'h33, 8'h33,
    8'hff, 8'hfb, 8'ha8, 8'hff, 8'hff, 8'h3f,
    8'h77, 8'h80, 8'h77, 8'h80, 8'h80, 8'h37, 8'h03, 8'h81, 8'h08,
    8'hf0, 8'hff, 8'h1f, 8'hf8, 8'hf8, 8'h20, 8'h3f
  };

  localparam logic [7:0] WR_RESET [NUM_WR] = '{
    8'h06, 8'h90, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h40, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'hff, 8'hff, 8'hff,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam wr_kind_t WR_KIND [NUM_WR] = '{
    WK_MASKED, WK_CLEAR, WK_CLEAR, WK_MASKED, WK_ONCE, WK_ONCE, WK_ONCE, WK_ONCE,
    WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED,
    WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED,
    WK_SMRAM, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED,
    WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED,
    WK_MASKED, WK_MASKED,
    WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED, WK_MASKED
  };

  // Read-only bytes: fixed values, zero where not listed
  function automatic logic [7:0] ro_byte(input logic [ADDR_W-1:0] a);
    logic [7:0] v;
    v = 8'h00;
    case (a)
      8'h00:   v = 8'h86;
      8'h01:   v = 8'h80;
      8'h02:   v = 8'h30;
      8'h03:   v = 8'h11;
      8'h08:   v = 8'h02;
      8'h0b:   v = 8'h06;
      8'h10:   v = 8'h08;
      8'h34:   v = 8'ha0;
      8'h88:   v = 8'h09;
      8'h89:   v = 8'ha0;
      8'h8a:   v = 8'h04;
      8'h8b:   v = 8'hf1;
      8'h95:   v = 8'hff;
      8'ha0:   v = 8'h02;
      8'ha2:   v = 8'h20;
      8'ha4:   v = 8'h07;
      8'ha5:   v = 8'h02;
      8'ha7:   v = 8'h1f;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/pci_config_register_file.sv
// PCI north-bridge configuration space, function 0, 256 bytes.
//
// Input channel (in_valid/in_ready): one byte access per item.
//   in_command 0 = read, 1 = write; in_function_number selects the function,
//   only function 0 exists; in_reg_address is the byte offset.
// Result channel (out_valid/out_ready): one item per read, carrying
//   out_read_data; reads of a nonzero function return 0xff. Writes produce
//   no result item.
// A read result is presented the cycle after the read is accepted.
// Throughput: one item per cycle unless stalled. A write is applied at the
//   edge that accepts it; a read the following cycle sees the new value.
// Only the 43 writable bytes are flops; every other byte is a constant.
//   Each writable byte compares the address itself and muxes onto the
//   read bus, one address decode plus an OR tree per cycle.
// Stall: in_ready drops only while a read result sits unconsumed in the
//   output register and out_ready is low; it is taken in the cycle the
//   receiver accepts that result.
// Reset (rst_n low, synchronous): all bytes return to their power-on
//   values, the SMRAM lock and write-once bytes release, and any pending
//   result item is dropped.
module pci_config_register_file (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_command,
  input  logic [2:0]                   in_function_number,
  input  logic [pcicfg_pkg::ADDR_W-1:0] in_reg_address,
  input  logic [7:0]                   in_write_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_read_data
);
  import pcicfg_pkg::*;

  logic [7:0] wr_r   [NUM_WR];
  logic [7:0] wr_nxt [NUM_WR];
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] out_data_r;
  logic [7:0] out_data_nxt;
  logic       in_fire;
  logic       fn0;

  assign in_ready      = !out_valid_r || out_ready;
  assign in_fire       = in_valid && in_ready;
  assign fn0           = (in_function_number == 3'd0);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

  // Per-byte update: each writable byte decodes its own address
  always_comb begin
    for (int i = 0; i < NUM_WR; i++) begin
      wr_nxt[i] = wr_r[i];
      if (in_fire && (in_command == CMD_WRITE) && fn0 &&
          (in_reg_address == WR_ADDR[i])) begin
        case (WR_KIND[i])
          WK_MASKED: wr_nxt[i] = in_write_data & WR_MASK[i];
          WK_CLEAR:  wr_nxt[i] = wr_r[i] & in_write_data & WR_MASK[i];
          WK_ONCE:   wr_nxt[i] = (wr_r[i] == 8'h00) ? in_write_data : wr_r[i];
          WK_SMRAM:  wr_nxt[i] = wr_r[i][SMRAM_LOCK_BIT] ? wr_r[i] : in_write_data;
          default:   wr_nxt[i] = wr_r[i];
        endcase
      end
    end
  end

  // Read path: writable bytes OR onto the bus, constants fill the rest; absent functions read 0xff
  always_comb begin
    logic [7:0] rd_bus;
    logic       rd_hit;
    rd_bus = 8'h00;
    rd_hit = 1'b0;
    for (int i = 0; i < NUM_WR; i++) begin
      if (in_reg_address == WR_ADDR[i]) begin
        rd_bus = rd_bus | wr_r[i];
        rd_hit = 1'b1;
      end
    end
    if (!fn0) begin
      out_data_nxt = ABSENT_FN_DATA;
    end else if (rd_hit) begin
      out_data_nxt = rd_bus;
    end else begin
      out_data_nxt = ro_byte(in_reg_address);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_fire) begin
      out_valid_nxt = (in_command == CMD_READ);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_WR; i++) begin
        wr_r[i] <= WR_RESET[i];
      end
    end else begin
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < NUM_WR; i++) begin
        wr_r[i] <= wr_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && (in_command == CMD_READ)) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_absent_fn_reads_ff: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_command == CMD_READ) && !fn0
      |=> out_valid && (out_read_data == ABSENT_FN_DATA))
    else $error("absent function read did not return 0xff");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_command == CMD_WRITE) |=> !out_valid)
    else $error("write produced a result item");

  a_smram_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    wr_r[SMRAM_IDX][SMRAM_LOCK_BIT] |=> $stable(wr_r[SMRAM_IDX]))
    else $error("locked SMRAM byte changed");

  a_subsys_write_once: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_r[SUBSYS_IDX] != 8'h00) |=> $stable(wr_r[SUBSYS_IDX]))
    else $error("nonzero subsystem byte changed");
`endif

endmodule

>>> dv/tb_pci_config_register_file.sv
`timescale 1ns / 100ps

// Bench for the north-bridge configuration space. A shadow image of the 256
// bytes tracks every accepted write; each accepted read pushes the byte it
// should return, and each result item is matched against the oldest entry.
module tb_pci_config_register_file;
  import pcicfg_pkg::*;

  localparam logic [2:0] HOST_FN      = 3'd0;   // the only function that exists
  localparam int         OPEN_ROWS    = 21;     // rows walked right after reset
  localparam int         DRILL_ROWS   = 26;     // all rows; the last 5 close the run
  localparam int         RANDOM_ITEMS = 1425;
  localparam int         HOLD_CYCLES  = 300;
  localparam logic [7:0] SMRAM_ADDR   = 8'h70;

  // One directed access. lit_en marks rows whose read value is typed in.
  typedef struct packed {
    cmd_t              cmd;
    logic [2:0]        fn;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
    logic              lit_en;
    logic [7:0]        lit;
  } drill_row_t;

  // Opening rows: reset values, extremes, absent function, read-only bytes,
  // status clear, write-once, open SMRAM, masked. Closing rows lock the SMRAM
  // byte, which can only be released by reset, so that has to come last.
  localparam drill_row_t DRILL [DRILL_ROWS] = '{
    '{CMD_READ,  3'd0, 8'h00, 8'h00, 1'b1, 8'h86},
    '{CMD_READ,  3'd0, 8'hff, 8'hff, 1'b1, 8'h00},
    '{CMD_READ,  3'd7, 8'h00, 8'h00, 1'b1, 8'hff},
    '{CMD_WRITE, 3'd0, 8'h04, 8'hff, 1'b0, 8'h00},
    '{CMD_READ,  3'd0, 8'h04, 8'h00, 1'b1, 8'hff},
    '{CMD_WRITE, 3'd0, 8'h04, 8'h00, 1'b0, 8'h00},
    '{CMD_WRITE, 3'd7, 8'h04, 8'hff, 1'b0, 8'h00},
    '{CMD_READ,  3'd0, 8'h04, 8'h00, 1'b1, 8'h00},
    '{CMD_WRITE, 3'd0, 8'h00, 8'h00, 1'b0, 8'h00},
    '{CMD_READ,  3'd0, 8'h00, 8'h00, 1'b1, 8'h86},
    '{CMD_WRITE, 3'd0, 8'h06, 8'h10, 1'b0, 8'h00},
    '{CMD_READ,  3'd0, 8'h06, 8'h00, 1'b1, 8'h10},
    '{CMD_WRITE, 3'd0, 8'h07, 8'hff, 1'b0, 8'h00},
    '{CMD_READ,  3'd0, 8'h07, 8'h00, 1'b1, 8'h00},
    '{CMD_WRITE, 3'd0, 8'h2c, 8'h5a, 1'b0, 8'h00},
    '{CMD_WRITE, 3'd0, 8'h2c, 8'ha5, 1'b0, 8'h00},
    '{CMD_READ,  3'd0, 8'h2c, 8'h00, 1'b0, 8'h00},
    '{CMD_WRITE, 3'd0, 8'h70, 8'h01, 1'b0, 8'h00},
    '{CMD_READ,  3'd0, 8'h70, 8'h00, 1'b0, 8'h00},
    '{CMD_WRITE, 3'd0, 8'h5a, 8'hff, 1'b0, 8'h00},
    '{CMD_READ,  3'd0, 8'h5a, 8'h00, 1'b0, 8'h00},
    '{CMD_WRITE, 3'd0, 8'h70, 8'h02, 1'b0, 8'h00},
    '{CMD_READ,  3'd0, 8'h70, 8'h00, 1'b0, 8'h00},
    '{CMD_WRITE, 3'd0, 8'h70, 8'hfd, 1'b0, 8'h00},
    '{CMD_READ,  3'd0, 8'h70, 8'h00, 1'b1, 8'h02},
    '{CMD_READ,  3'd5, 8'h70, 8'h00, 1'b1, 8'hff}
  };

  logic              clk;
  logic              rst_n              = 1'b0;
  logic              in_valid           = 1'b0;
  logic              in_ready;
  cmd_t              in_command         = CMD_READ;
  logic [2:0]        in_function_number = 3'd0;
  logic [ADDR_W-1:0] in_reg_address     = '0;
  logic [7:0]        in_write_data      = 8'h00;
  logic              out_valid;
  logic              out_ready          = 1'b0;
  logic [7:0]        out_read_data;

  // Bench-side tags that travel with the payload: a typed-in read value.
  logic              in_lit_en          = 1'b0;
  logic [7:0]        in_lit             = 8'h00;

  // Shadow of the configuration space and the bytes owed by pending reads.
  logic [7:0]        cfg_image [SPACE_BYTES];
  logic [7:0]        read_expect [$];

  int  mismatches   = 0;
  int  reads_seen   = 0;
  int  absent_reads = 0;
  int  writes_seen  = 0;
  int  absent_writes = 0;
  int  sent         = 0;
  bit  quiet        = 1'b0;   // no idling on either side while set
  bit  hold_off     = 1'b0;   // asks the receiver for a long stall

  pci_config_register_file i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_command         (in_command),
    .in_function_number (in_function_number),
    .in_reg_address     (in_reg_address),
    .in_write_data      (in_write_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_read_data      (out_read_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Power-on contents: a handful of ID/capability bytes, zero elsewhere.
  task automatic load_power_on_image();
    for (int i = 0; i < SPACE_BYTES; i++) cfg_image[i] = 8'h00;
    cfg_image[8'h00] = 8'h86;
    cfg_image[8'h01] = 8'h80;
    cfg_image[8'h02] = 8'h30;
    cfg_image[8'h03] = 8'h11;
    cfg_image[8'h04] = 8'h06;
    cfg_image[8'h06] = 8'h90;
    cfg_image[8'h08] = 8'h02;
    cfg_image[8'h0b] = 8'h06;
    cfg_image[8'h10] = 8'h08;
    cfg_image[8'h34] = 8'ha0;
    cfg_image[8'h50] = 8'h40;
    cfg_image[8'h88] = 8'h09;
    cfg_image[8'h89] = 8'ha0;
    cfg_image[8'h8a] = 8'h04;
    cfg_image[8'h8b] = 8'hf1;
    cfg_image[8'h92] = 8'hff;
    cfg_image[8'h93] = 8'hff;
    cfg_image[8'h94] = 8'hff;
    cfg_image[8'h95] = 8'hff;
    cfg_image[8'ha0] = 8'h02;
    cfg_image[8'ha2] = 8'h20;
    cfg_image[8'ha4] = 8'h07;
    cfg_image[8'ha5] = 8'h02;
    cfg_image[8'ha7] = 8'h1f;
  endtask

  // Write behavior per address; returns 0 for read-only bytes.
  function automatic logic write_rule(input logic [7:0] a, output wr_kind_t kind,
                                      output logic [7:0] mask);
    logic hit;
    hit  = 1'b1;
    kind = WK_MASKED;
    mask = 8'h00;
    if (a >= 8'h5a && a <= 8'h5f) begin
      mask = 8'h33;
    end else begin
      case (a)
        8'h04, 8'h52, 8'h54, 8'h92, 8'h93, 8'hba: mask = 8'hff;
        8'h13: mask = 8'hfe;
        8'h50: mask = 8'hdc;
        8'h51: mask = 8'h07;
        8'h53: mask = 8'hf7;
        8'h56, 8'h99, 8'h9b, 8'h9d: mask = 8'h80;
        8'h59: mask = 8'h30;
        8'h72: mask = 8'hfb;
        8'h73: mask = 8'ha8;
        8'h94, 8'hcb: mask = 8'h3f;
        8'h98, 8'h9a: mask = 8'h77;
        8'ha8: mask = 8'h37;
        8'ha9: mask = 8'h03;
        8'hb0: mask = 8'h81;
        8'hb4: mask = 8'h08;
        8'hb9: mask = 8'hf0;
        8'hbb: mask = 8'h1f;
        8'hbc, 8'hbd: mask = 8'hf8;
        8'hbe: mask = 8'h20;
        8'h06: begin
          kind = WK_CLEAR;
          mask = 8'h90;
        end
        8'h07: begin
          kind = WK_CLEAR;
          mask = 8'hff;
        end
        8'h2c, 8'h2d, 8'h2e, 8'h2f: kind = WK_ONCE;
        SMRAM_ADDR: kind = WK_SMRAM;
        default: hit = 1'b0;
      endcase
    end
    return hit;
  endfunction

  // Applies one access to the shadow image; returns 1 when a read byte is owed.
  function automatic logic predict_access(input cmd_t c, input logic [2:0] f,
                                          input logic [7:0] a, input logic [7:0] d,
                                          output logic [7:0] rd);
    wr_kind_t   kind;
    logic [7:0] mask;
    rd = 8'h00;
    if (c == CMD_READ) begin
      rd = (f == HOST_FN) ? cfg_image[a] : ABSENT_FN_DATA;
      return 1'b1;
    end
    if (f == HOST_FN && write_rule(a, kind, mask)) begin
      case (kind)
        WK_MASKED: cfg_image[a] = d & mask;
        WK_CLEAR:  cfg_image[a] = cfg_image[a] & d & mask;
        WK_ONCE:   if (cfg_image[a] == 8'h00) cfg_image[a] = d;
        WK_SMRAM:  if (!cfg_image[a][SMRAM_LOCK_BIT]) cfg_image[a] = d;
        default: ;
      endcase
    end
    return 1'b0;
  endfunction

  // Sample both channels at the edge. A result leaving this edge always
  // belongs to an older read, so it is matched before the new item is logged.
  always @(posedge clk) begin : watch_ports
    logic [7:0] owed;
    logic       gives;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (read_expect.size() == 0) begin
          $display("%0t: result 0x%02h with no read pending", $time, out_read_data);
          mismatches++;
        end else begin
          owed = read_expect.pop_front();
          if (out_read_data !== owed) begin
            $display("%0t: read_data expected 0x%02h, got 0x%02h",
                     $time, owed, out_read_data);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        gives = predict_access(in_command, in_function_number, in_reg_address,
                               in_write_data, owed);
        if (gives) begin
          read_expect.push_back(in_lit_en ? in_lit : owed);
          reads_seen++;
          if (in_function_number != HOST_FN) absent_reads++;
        end else begin
          writes_seen++;
          if (in_function_number != HOST_FN) absent_writes++;
        end
      end
    end
  end

  // Receiver: ~9% random stalls, none during the quiet stretch, and one long
  // stall on request, counted here while the sender keeps pushing items.
  initial begin : drive_out_ready
    forever begin
      @(posedge clk);
      if (hold_off) begin
        repeat (HOLD_CYCLES) begin
          out_ready <= 1'b0;
          @(posedge clk);
        end
        hold_off = 1'b0;
      end
      out_ready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  // Offer one item and hold it until the edge that takes it.
  task automatic offer_item(input cmd_t c, input logic [2:0] f, input logic [7:0] a,
                            input logic [7:0] d, input logic le, input logic [7:0] lv);
    if (!quiet && $urandom_range(99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_command         <= c;
    in_function_number <= f;
    in_reg_address     <= a;
    in_write_data      <= d;
    in_lit_en          <= le;
    in_lit             <= lv;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic walk_drill(input int first, input int last);
    for (int i = first; i < last; i++)
      offer_item(DRILL[i].cmd, DRILL[i].fn, DRILL[i].addr, DRILL[i].data,
                 DRILL[i].lit_en, DRILL[i].lit);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (read_expect.size() != 0);
  endtask

  initial begin : stimulus
    wr_kind_t   k;
    logic [7:0] m;
    logic [7:0] a;
    logic [7:0] d;
    logic [2:0] f;
    cmd_t       c;
    bit         did_hold;
    bit         did_pause;
    did_hold  = 1'b0;
    did_pause = 1'b0;
    load_power_on_image();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    walk_drill(0, OPEN_ROWS);

    // Random part. Most items are write/read-back pairs on writable bytes;
    // the rest hit any address, any function, either command. SMRAM writes
    // keep the lock bit clear so the closing rows still find it open.
    while (sent < OPEN_ROWS + RANDOM_ITEMS) begin
      if (!did_hold && sent >= 400) begin
        hold_off = 1'b1;
        did_hold = 1'b1;
      end
      if (!did_pause && sent >= 800) begin
        pause_until_drained();
        did_pause = 1'b1;
      end
      quiet = (sent >= 900 && sent < 1100);
      d = 8'($urandom_range(255));
      if ($urandom_range(99) < 55) begin
        do a = 8'($urandom_range(255)); while (!write_rule(a, k, m));
        if (a == SMRAM_ADDR) d[SMRAM_LOCK_BIT] = 1'b0;
        offer_item(CMD_WRITE, HOST_FN, a, d, 1'b0, 8'h00);
        offer_item(CMD_READ, HOST_FN, a, 8'($urandom_range(255)), 1'b0, 8'h00);
      end else begin
        c = $urandom_range(1) ? CMD_WRITE : CMD_READ;
        f = ($urandom_range(99) < 75) ? HOST_FN : 3'($urandom_range(7));
        if ($urandom_range(99) < 60) begin
          do a = 8'($urandom_range(255)); while (!write_rule(a, k, m));
        end else begin
          a = 8'($urandom_range(255));
        end
        if (c == CMD_WRITE && a == SMRAM_ADDR) d[SMRAM_LOCK_BIT] = 1'b0;
        offer_item(c, f, a, d, 1'b0, 8'h00);
      end
    end
    quiet = 1'b0;

    walk_drill(OPEN_ROWS, DRILL_ROWS);

    in_valid <= 1'b0;
    do @(posedge clk); while (read_expect.size() != 0);
    repeat (10) @(posedge clk);

    $display("Covered %0d reads (%0d to absent functions) and %0d writes (%0d ignored",
             reads_seen, absent_reads, writes_seen, absent_writes);
    $display("  as absent-function writes), with a %0d-cycle receiver stall and a drain.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : run_limit
    #2_000_000;
    $display("%0t: run timed out with %0d reads pending", $time, read_expect.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
